// ===== sv/ttcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the text terminal cursor and scroll unit.
// ----------------------------------------------------------------------------
package ttcs_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  BLANK_CODE   = 8'd32;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;
	localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, BLANK_CODE};

	localparam logic [1:0] OP_PUTCHAR = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_CLEAR   = 2'd3;

	typedef struct packed {
		logic accept;
		logic sweep_run;
		logic rd_done;
	} ttcs_cmd_t;

	typedef struct packed {
		logic need_sweep;
		logic is_read;
		logic sweep_last;
		logic out_busy;
	} ttcs_status_t;

endpackage

// ===== sv/ttcs_ram.sv =====
// ----------------------------------------------------------------------------
// ttcs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ttcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/ttcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcs_ctrl
// Controller: sequences item acceptance, the delayed read result and the
// screen sweeps used for reset fill, clear and scroll.
// ----------------------------------------------------------------------------
module ttcs_ctrl
	import ttcs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ttcs_status_t status,
	output ttcs_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && !status.out_busy;
	assign accept   = in_valid && in_ready;

	assign cmd.accept    = accept;
	assign cmd.sweep_run = (state_q == S_SWEEP);
	assign cmd.rd_done   = (state_q == S_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (status.need_sweep) begin
						state_d = S_SWEEP;
					end else if (status.is_read) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_SWEEP: begin
				if (status.sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/ttcs_dp.sv =====
// ----------------------------------------------------------------------------
// ttcs_dp
// Datapath: cursor, text color, screen memory access, sweep address
// pipeline and the output beat register.
// ----------------------------------------------------------------------------
module ttcs_dp
	import ttcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ttcs_cmd_t          cmd,
	output ttcs_status_t       status,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_wdata,
	input  logic [1:0]         op,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] entry_color,
	input  logic [ROW_W-1:0]   cell_row,
	input  logic [COL_W-1:0]   cell_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [COL_W-1:0]   cursor_col,
	output logic [CELL_W-1:0]  cell_value,
	output logic               scrolled
);

	logic [COLOR_W-1:0] text_color_q;
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;

	logic [ADDR_W-1:0]  cnt_q;
	logic               copy_q;
	logic [CELL_W-1:0]  fill_q;
	logic               wr_v_s1;
	logic               from_ram_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;
	logic               rd_hit_q;
	logic               out_valid_q;

	logic [ADDR_W-1:0]  cur_addr;
	logic [ADDR_W-1:0]  cell_addr;
	logic               in_range;
	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic               wrap;
	logic               scroll;
	logic [ROW_W-1:0]   row_next;
	logic [COL_W-1:0]   col_next;
	logic               need_sweep;
	logic               copy_ok;
	logic [ADDR_W-1:0]  copy_src;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	assign cur_addr  = ADDR_W'(cur_row_q * COLUMNS) + ADDR_W'(cur_col_q);
	assign cell_addr = ADDR_W'(cell_row * COLUMNS) + ADDR_W'(cell_col);
	assign in_range  = (32'(cell_row) < ROWS) && (32'(cell_col) < COLUMNS);

	assign col_inc = {1'b0, cur_col_q} + 1'b1;
	assign row_inc = {1'b0, cur_row_q} + 1'b1;
	assign wrap    = (char_code == NEWLINE_CODE) || (32'(col_inc) >= COLUMNS);
	assign scroll  = wrap && (32'(row_inc) >= ROWS);

	always_comb begin
		row_next = cur_row_q;
		col_next = col_inc[COL_W-1:0];
		if (wrap) begin
			col_next = '0;
			row_next = scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
		end
	end

	assign need_sweep = (op == OP_CLEAR) || ((op == OP_PUTCHAR) && scroll);

	assign status.need_sweep = need_sweep;
	assign status.is_read    = (op == OP_READ);
	assign status.sweep_last = (32'(cnt_q) == CELLS - 1);
	assign status.out_busy   = out_valid_q && !out_ready;

	assign copy_src = cnt_q + ADDR_W'(COLUMNS);
	assign copy_ok  = copy_q && (32'(cnt_q) < CELLS - COLUMNS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_addr;
		ram_wdata = {text_color_q, char_code};
		if (wr_v_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wr_addr_s1;
			ram_wdata = from_ram_s1 ? ram_rdata : fill_q;
		end else if (cmd.accept) begin
			if ((op == OP_PUTCHAR) && (char_code != NEWLINE_CODE)) begin
				ram_we = 1'b1;
			end else if ((op == OP_WRITE) && in_range) begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr;
				ram_wdata = {entry_color, char_code};
			end
		end
	end

	assign ram_raddr = cmd.sweep_run ? copy_src : cell_addr;

	ttcs_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cnt_q        <= '0;
			copy_q       <= 1'b0;
			fill_q       <= RESET_CELL;
			wr_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			wr_v_s1 <= cmd.sweep_run;
			if (cmd.accept && need_sweep) begin
				cnt_q  <= '0;
				copy_q <= (op == OP_PUTCHAR);
				fill_q <= {text_color_q, BLANK_CODE};
			end else if (cmd.sweep_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.accept) begin
				unique case (op)
					OP_PUTCHAR: begin
						cur_row_q <= row_next;
						cur_col_q <= col_next;
					end
					OP_CLEAR: begin
						cur_row_q <= '0;
						cur_col_q <= '0;
					end
					OP_WRITE, OP_READ: begin
					end
				endcase
			end
			if ((cmd.accept && (op != OP_READ)) || cmd.rd_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		from_ram_s1 <= copy_ok;
		wr_addr_s1  <= cnt_q;
		if (cmd.accept) begin
			rd_hit_q <= in_range;
		end
		if (cmd.accept && (op != OP_READ)) begin
			cell_value <= '0;
			unique case (op)
				OP_PUTCHAR: begin
					cursor_row <= row_next;
					cursor_col <= col_next;
					scrolled   <= scroll;
				end
				OP_CLEAR: begin
					cursor_row <= '0;
					cursor_col <= '0;
					scrolled   <= 1'b0;
				end
				OP_WRITE, OP_READ: begin
					cursor_row <= cur_row_q;
					cursor_col <= cur_col_q;
					scrolled   <= 1'b0;
				end
			endcase
		end else if (cmd.rd_done) begin
			cursor_row <= cur_row_q;
			cursor_col <= cur_col_q;
			scrolled   <= 1'b0;
			cell_value <= rd_hit_q ? ram_rdata : '0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/text_terminal_cursor_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cursor_scroll_unit
// Text-mode terminal screen memory with cursor, putchar, cell write/read,
// clear and scroll-up on passing the last row.
// ----------------------------------------------------------------------------
// Result beat: registered on accept, so valid in the cycle after it; a
// read-cell result passes the S_READ state first. Putchar and write-cell
// are taken one per cycle unless a scroll or a stalled out_ready holds
// them off; a read-cell holds off the next item. Scroll and clear sweep
// the screen RAM one cell a cycle with in_ready low. Reset: cursor home,
// color 7; a fill pass writes every cell to a blank in color 7 before the first item is taken.
module text_terminal_cursor_scroll_unit
	import ttcs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COLOR_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic [COLOR_W-1:0] entry_color,
	input  logic [ROW_W-1:0]   cell_row,
	input  logic [COL_W-1:0]   cell_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [COL_W-1:0]   cursor_col,
	output logic [CELL_W-1:0]  cell_value,
	output logic               scrolled
);

	ttcs_cmd_t    cmd;
	ttcs_status_t status;

	ttcs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	ttcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.char_code  (char_code),
		.entry_color(entry_color),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.cell_value (cell_value),
		.scrolled   (scrolled)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - text terminal cursor and scroll unit testbench
// Drives putchar, write-cell, read-cell and clear beats through the input
// channel and checks every result beat against an in-bench screen predictor
// (cells, cursor, text color). Covers range edges, line wrap, newline,
// scroll-up, clear, color changes, random input and output stalls, and a long
// output hold-off that backs the unit up.
// ----------------------------------------------------------------------------
module tb;
	import ttcs_pkg::*;

	localparam int SETTLE_CYCLES = CELLS + 1 + 100;
	localparam int STALL_LIMIT   = 50000;
	localparam int CYCLE_LIMIT   = 20000000;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CELL_W-1:0] value;
		logic              scroll;
	} term_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COLOR_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = OP_PUTCHAR;
	logic [CHAR_W-1:0]  char_code = '0;
	logic [COLOR_W-1:0] entry_color = '0;
	logic [ROW_W-1:0]   cell_row = '0;
	logic [COL_W-1:0]   cell_col = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ROW_W-1:0]   cursor_row;
	logic [COL_W-1:0]   cursor_col;
	logic [CELL_W-1:0]  cell_value;
	logic               scrolled;

	logic [CELL_W-1:0]  screen_model [CELLS];
	int unsigned        cur_row_model;
	int unsigned        cur_col_model;
	logic [COLOR_W-1:0] color_model = RESET_COLOR;
	term_result_t       pending_results [$];

	int errors = 0;
	int send_idle_pct = 10;
	int recv_idle_pct = 10;
	int hold_cycles = 0;
	int stall_count = 0;
	int cycle_count = 0;
	int n_putchar = 0;
	int n_write = 0;
	int n_read = 0;
	int n_clear = 0;
	int n_scroll = 0;
	int n_color = 0;

	text_terminal_cursor_scroll_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.char_code   (char_code),
		.entry_color (entry_color),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cursor_row  (cursor_row),
		.cursor_col  (cursor_col),
		.cell_value  (cell_value),
		.scrolled    (scrolled)
	);

	always #10 clk = ~clk;

	task blank_screen_model();
		for (int i = 0; i < CELLS; i++) begin
			screen_model[i] = {color_model, BLANK_CODE};
		end
	endtask

	task advance_row(output bit did_scroll);
		did_scroll = 1'b0;
		cur_col_model = 0;
		cur_row_model++;
		if (cur_row_model >= ROWS) begin
			for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
				screen_model[i] = screen_model[i + COLUMNS];
			end
			for (int c = 0; c < COLUMNS; c++) begin
				screen_model[(ROWS - 1) * COLUMNS + c] = {color_model, BLANK_CODE};
			end
			cur_row_model = ROWS - 1;
			did_scroll = 1'b1;
			n_scroll++;
		end
	endtask

	task predict_terminal(input logic [1:0] code, input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] color, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		term_result_t res;
		bit hit;
		bit sc;
		res = '0;
		sc = 1'b0;
		hit = (r < ROWS) && (c < COLUMNS);
		case (code)
			OP_PUTCHAR: begin
				n_putchar++;
				if (ch == NEWLINE_CODE) begin
					advance_row(sc);
				end else begin
					screen_model[cur_row_model * COLUMNS + cur_col_model] = {color_model, ch};
					cur_col_model++;
					if (cur_col_model >= COLUMNS)
						advance_row(sc);
				end
			end
			OP_WRITE: begin
				n_write++;
				if (hit)
					screen_model[r * COLUMNS + c] = {color, ch};
			end
			OP_READ: begin
				n_read++;
				if (hit)
					res.value = screen_model[r * COLUMNS + c];
			end
			default: begin
				n_clear++;
				blank_screen_model();
				cur_row_model = 0;
				cur_col_model = 0;
			end
		endcase
		res.row = cur_row_model[ROW_W-1:0];
		res.col = cur_col_model[COL_W-1:0];
		res.scroll = sc;
		pending_results.push_back(res);
	endtask

	// enter and leave just after a falling edge
	task send_item(input logic [1:0] code, input logic [CHAR_W-1:0] ch,
			input logic [COLOR_W-1:0] color, input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		op = code;
		char_code = ch;
		entry_color = color;
		cell_row = r;
		cell_col = c;
		do @(posedge clk); while (!in_ready);
		predict_terminal(code, ch, color, r, c);
		@(negedge clk);
	endtask

	task send_random_item();
		logic [1:0]         code;
		logic [CHAR_W-1:0]  ch;
		logic [COLOR_W-1:0] color;
		logic [ROW_W-1:0]   r;
		logic [COL_W-1:0]   c;
		int                 pick;
		pick = $urandom_range(99);
		ch = CHAR_W'($urandom_range(255));
		color = COLOR_W'($urandom_range(255));
		r = ROW_W'($urandom_range(31));
		c = COL_W'($urandom_range(127));
		if (pick < 55) begin
			code = OP_PUTCHAR;
			if ($urandom_range(99) < 30)
				ch = NEWLINE_CODE;
		end else if (pick < 99) begin
			code = (pick < 74) ? OP_WRITE : OP_READ;
			if ($urandom_range(99) < 80) begin
				r = ($urandom_range(99) < 40) ? ROW_W'(cur_row_model) :
					ROW_W'($urandom_range(ROWS - 1));
				c = COL_W'($urandom_range(COLUMNS - 1));
			end
		end else begin
			code = OP_CLEAR;
		end
		send_item(code, ch, color, r, c);
	endtask

	task wait_results_done();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// let any scroll or clear sweep finish before touching the color
	task settle();
		wait_results_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_text_color(input logic [COLOR_W-1:0] color);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = color;
		@(negedge clk);
		cfg_we = 1'b0;
		color_model = color;
		n_color++;
	endtask

	task report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task test_directed();
		send_item(OP_READ, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)), 0, 0);
		send_item(OP_PUTCHAR, 8'h41, COLOR_W'($urandom_range(255)),
			ROW_W'($urandom_range(31)), 0);
		send_item(OP_PUTCHAR, 8'h00, 8'h00, 0, 0);
		send_item(OP_PUTCHAR, 8'hFF, 8'hFF, 5'h1F, 7'h7F);
		send_item(OP_PUTCHAR, NEWLINE_CODE, COLOR_W'($urandom_range(255)), 0, 0);
		send_item(OP_READ, 0, 0, 0, 0);
		send_item(OP_READ, 0, 0, 0, 1);
		send_item(OP_READ, 0, 0, 0, 2);
		send_item(OP_WRITE, 8'hFF, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_item(OP_WRITE, 8'h00, 8'h00, 0, 0);
		send_item(OP_READ, 8'hFF, 8'hFF, 0, 0);
		send_item(OP_WRITE, 8'h5A, 8'hA5, 5'h1F, 7'h7F);
		send_item(OP_WRITE, 8'h5A, 8'hA5, ROW_W'(ROWS), 0);
		send_item(OP_WRITE, 8'h5A, 8'hA5, 0, COL_W'(COLUMNS));
		send_item(OP_READ, 0, 0, 5'h1F, 7'h7F);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS), 0);
		send_item(OP_READ, 0, 0, 0, COL_W'(COLUMNS));
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_item(OP_CLEAR, CHAR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)), 3, 3);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
		send_item(OP_READ, 0, 0, 0, 0);
		send_item(OP_PUTCHAR, 8'h5A, 0, 0, 0);
	endtask

	task test_scroll();
		logic [CHAR_W-1:0] ch;
		send_item(OP_CLEAR, 0, 0, 0, 0);
		send_item(OP_WRITE, 8'h21, 8'h3C, 0, 7);
		send_item(OP_WRITE, 8'h22, 8'hC3, 1, 7);
		for (int i = 0; i < ROWS - 1; i++)
			send_item(OP_PUTCHAR, NEWLINE_CODE, COLOR_W'($urandom_range(255)), 0, 0);
		for (int i = 0; i < COLUMNS; i++) begin
			ch = CHAR_W'($urandom_range(255));
			if (ch == NEWLINE_CODE)
				ch = 8'h2E;
			send_item(OP_PUTCHAR, ch, COLOR_W'($urandom_range(255)),
				ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
		end
		send_item(OP_READ, 0, 0, 0, 7);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 2), 0);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 1), 0);
		send_item(OP_PUTCHAR, 8'h41, 0, 0, 0);
		send_item(OP_PUTCHAR, NEWLINE_CODE, 0, 0, 0);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 2), 0);
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 3), COL_W'(COLUMNS - 1));
		send_item(OP_READ, 0, 0, ROW_W'(ROWS - 1), 0);
	endtask

	task test_backpressure();
		send_idle_pct = 0;
		hold_cycles = 500;
		for (int i = 0; i < 40; i++)
			send_random_item();
		wait_results_done();
		for (int i = 0; i < 20; i++)
			send_random_item();
	endtask

	task test_random(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++)
			send_random_item();
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready = 1'b0;
			hold_cycles--;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		term_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", cell_value, 0);
			end else begin
				want = pending_results.pop_front();
				if (cursor_row !== want.row)
					report_mismatch("cursor_row", cursor_row, want.row);
				if (cursor_col !== want.col)
					report_mismatch("cursor_col", cursor_col, want.col);
				if (cell_value !== want.value)
					report_mismatch("cell_value", cell_value, want.value);
				if (scrolled !== want.scroll)
					report_mismatch("scrolled", scrolled, want.scroll);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count > STALL_LIMIT || cycle_count > CYCLE_LIMIT) begin
			$display("Timeout at cycle %0d with %0d results pending", cycle_count,
				pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		blank_screen_model();
		cur_row_model = 0;
		cur_col_model = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		settle();
		test_directed();
		write_text_color(8'h00);
		test_scroll();
		write_text_color(8'hFF);
		test_backpressure();
		write_text_color(COLOR_W'($urandom_range(255)));
		test_random(600, 23, 70);
		write_text_color(COLOR_W'($urandom_range(255)));
		test_random(600, 70, 23);
		write_text_color(8'h1F);
		test_random(500, 0, 0);
		settle();
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", 0, pending_results.size());
		$display("Ran %0d putchar, %0d write, %0d read and %0d clear beats", n_putchar,
			n_write, n_read, n_clear);
		$display("Saw %0d scrolls across %0d color settings; %0d mismatches", n_scroll,
			n_color + 1, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
